// ----- sv/slri_pkg.sv -----
// Package for the sorted list: capacity, codes and beat payload types.
`default_nettype none
package slri_pkg;

   localparam int CAPACITY = 16;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int VALUE_W  = 32;

   typedef enum logic {
      MODE_INSERT = 1'b0,
      MODE_REMOVE = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2
   } status_type;

   typedef struct packed {
      mode_type                    mode;
      logic signed [VALUE_W-1:0]   value;
   } req_type;

   typedef struct packed {
      status_type                  status;
      logic [4:0]                  entry_count;
      logic signed [VALUE_W-1:0]   smallest_value;
   } rsp_type;

   // Broadcast from the top level to every cell for one operation.
   typedef struct packed {
      logic                        insert_en;
      logic                        remove_en;
      logic signed [VALUE_W-1:0]   value;
   } cell_cmd_type;

endpackage
`default_nettype wire

// ----- sv/slri_cell.sv -----
// One storage cell of the sorted chain: compare against the key, keep or shift.
`default_nettype none
module slri_cell (
   input  wire logic                                   clock,
   input  wire logic                                   occupied,
   input  wire slri_pkg::cell_cmd_type                 cmd,
   input  wire logic                                   left_le,
   input  wire logic signed [slri_pkg::VALUE_W-1:0]    left_entry,
   input  wire logic signed [slri_pkg::VALUE_W-1:0]    right_entry,
   output logic                                        le,
   output logic                                        eq,
   output logic signed [slri_pkg::VALUE_W-1:0]         entry_ff,
   output logic signed [slri_pkg::VALUE_W-1:0]         entry_in
);

   logic lt;

   always_comb begin
      le = occupied && (entry_ff <= cmd.value);
      lt = occupied && (entry_ff < cmd.value);
      eq = occupied && (entry_ff == cmd.value);
   end

   // Insert: cells past the slot take the left neighbor, the slot takes the key.
   // Remove: cells from the first match onward take the right neighbor.
   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert_en && !le) begin
         entry_in = left_le ? cmd.value : left_entry;
      end else if (cmd.remove_en && !lt) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
`default_nettype wire

// ----- sv/sorted_list_insert_remove.sv -----
// Top level of the sorted list engine: cell chain, entry count and response register.
`default_nettype none
// Sorted list engine. Holds up to slri_pkg::CAPACITY signed 32-bit values in
// ascending order in a chain of cells. Each request beat is an insert (placed
// after every equal or smaller entry, so equal values keep arrival order) or a
// remove (deletes the first equal entry). Every request gives exactly one
// response beat: status (done, full, not found), the entry count after the
// operation and the smallest stored value (zero when empty). Throughput is one
// beat per cycle: every cell compares against the key and shifts toward its
// neighbor in the same cycle, so the whole table updates at once. The response
// appears in the cycle after the request is taken, from an output register; a
// new request is taken while the response register is empty or being drained.
// A refused insert or remove leaves the table unchanged. No clearing pass is
// needed after reset; only the entry count and response valid are reset.
module sorted_list_insert_remove (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire slri_pkg::req_type    req_payload,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output slri_pkg::rsp_type         rsp_payload
);

   localparam int N = slri_pkg::CAPACITY;

   logic                                   accept;
   logic                                   full;
   logic                                   found;
   slri_pkg::cell_cmd_type                 cmd;
   logic [N-1:0]                           occupied;
   logic [N-1:0]                           le;
   logic [N-1:0]                           eq;
   logic signed [slri_pkg::VALUE_W-1:0]    entry_q [N];
   logic signed [slri_pkg::VALUE_W-1:0]    entry_next [N];

   logic [slri_pkg::COUNT_W-1:0]           count_ff;
   logic [slri_pkg::COUNT_W-1:0]           count_in;
   logic                                   rsp_valid_ff;
   logic                                   rsp_valid_in;
   slri_pkg::rsp_type                      rsp_payload_ff;
   slri_pkg::rsp_type                      rsp_payload_in;

   // Take a beat whenever the response register is free or draining.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign full  = (count_ff == slri_pkg::COUNT_W'(N));
   assign found = |eq;

   always_comb begin
      cmd.value     = req_payload.value;
      cmd.insert_en = accept && (req_payload.mode == slri_pkg::MODE_INSERT) && !full;
      cmd.remove_en = accept && (req_payload.mode == slri_pkg::MODE_REMOVE) && found;
   end

   // Chain of cells; cell 0 sees an always-true left compare, the last cell
   // shifts in the key (lands in a slot that is no longer occupied).
   for (genvar i = 0; i < N; i++) begin : g_cell
      assign occupied[i] = (slri_pkg::COUNT_W'(i) < count_ff);

      if (i == 0) begin : g_first
         if (N > 1) begin : g_more
            slri_cell u_cell (
               .clock       (clock),
               .occupied    (occupied[i]),
               .cmd         (cmd),
               .left_le     (1'b1),
               .left_entry  (req_payload.value),
               .right_entry (entry_q[i+1]),
               .le          (le[i]),
               .eq          (eq[i]),
               .entry_ff    (entry_q[i]),
               .entry_in    (entry_next[i])
            );
         end else begin : g_only
            slri_cell u_cell (
               .clock       (clock),
               .occupied    (occupied[i]),
               .cmd         (cmd),
               .left_le     (1'b1),
               .left_entry  (req_payload.value),
               .right_entry (req_payload.value),
               .le          (le[i]),
               .eq          (eq[i]),
               .entry_ff    (entry_q[i]),
               .entry_in    (entry_next[i])
            );
         end
      end else if (i == N - 1) begin : g_last
         slri_cell u_cell (
            .clock       (clock),
            .occupied    (occupied[i]),
            .cmd         (cmd),
            .left_le     (le[i-1]),
            .left_entry  (entry_q[i-1]),
            .right_entry (req_payload.value),
            .le          (le[i]),
            .eq          (eq[i]),
            .entry_ff    (entry_q[i]),
            .entry_in    (entry_next[i])
         );
      end else begin : g_mid
         slri_cell u_cell (
            .clock       (clock),
            .occupied    (occupied[i]),
            .cmd         (cmd),
            .left_le     (le[i-1]),
            .left_entry  (entry_q[i-1]),
            .right_entry (entry_q[i+1]),
            .le          (le[i]),
            .eq          (eq[i]),
            .entry_ff    (entry_q[i]),
            .entry_in    (entry_next[i])
         );
      end
   end

   // Count and response for the beat being taken.
   always_comb begin
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      if (cmd.insert_en) begin
         count_in = count_ff + slri_pkg::COUNT_W'(1);
      end else if (cmd.remove_en) begin
         count_in = count_ff - slri_pkg::COUNT_W'(1);
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         if (req_payload.mode == slri_pkg::MODE_INSERT) begin
            rsp_payload_in.status = full ? slri_pkg::STATUS_FULL : slri_pkg::STATUS_DONE;
         end else begin
            rsp_payload_in.status = found ? slri_pkg::STATUS_DONE
                                          : slri_pkg::STATUS_NOT_FOUND;
         end
         rsp_payload_in.entry_count    = 5'(count_in);
         rsp_payload_in.smallest_value = (count_in == '0) ? '0 : entry_next[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
`default_nettype wire
